// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types, widths and codes for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int NUM_PAGES_DEF = 1024;
    localparam int PAGE_BYTES    = 4096;

    localparam int SIZE_W      = 23;
    localparam int PAGE_W      = 10;
    localparam int FREED_W     = 11;
    localparam int HARD_W      = 10;
    localparam int SMALL_W     = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 1'b1;

    localparam logic [HARD_W-1:0]  HARD_LIMIT_RST  = 10'd0;
    localparam logic [SMALL_W-1:0] SMALL_LIMIT_RST = 13'd2048;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_NOTHING  = 3'd2,
        ST_BLOCK    = 3'd3,
        ST_ZERO     = 3'd4,
        ST_INVALID  = 3'd5
    } status_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [SIZE_W-1:0]   size_bytes;
        logic [PAGE_W-1:0]   page_index;
    } in_t;

    typedef struct packed {
        status_t             status;
        logic [PAGE_W-1:0]   start_page;
        logic [FREED_W-1:0]  freed_pages;
    } out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FREE_CHK,
        S_SCAN,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic check;
        logic free_chk;
        logic scan_rd;
        logic scan_chk;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic early_done;
        logic is_free;
        logic idx_out;
        logic fit;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/first_fit_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit
// First-fit page allocator over a heap of NUM_PAGES pages.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request beat: allocate (size in bytes)
//   or free (page index). m_valid/m_ready/m_data return exactly one result
//   beat per request: status, start page of a new run, pages released.
//   cfg_we/cfg_index/cfg_wdata write hard_limit_page (0) and
//   small_block_limit (1); write only while no request is in flight.
// Reset:
//   Both limits return to their defaults and the run table is cleared one
//   entry per cycle, with s_ready low the whole time.
// Sequencing:
//   One request at a time. After acceptance the request is checked against
//   the limits; one that the limits alone decide goes straight to the result,
//   a free first reads its table entry, and an allocate scans the run table,
//   reading an entry (each free page, plus one per allocated run hopped) and
//   then checking it, until a gap fits or the scan passes the last page.
//   s_ready is back high in the cycle m_valid rises.
//   The result register decouples the sides: a new request is accepted while
//   a result beat waits, and the block holds in its final state only if the
//   next result is ready before m_ready frees the register.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ffpa_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ffpa_pkg::out_t                      m_data,
    input  logic                                cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [ffpa_pkg::HARD_W-1:0]  limit_page_reg;
    logic [ffpa_pkg::SMALL_W-1:0] small_limit_reg;

    ffpa_pkg::ctrl_cmd_t cmd;
    ffpa_pkg::dp_sts_t   sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_page_reg  <= ffpa_pkg::HARD_LIMIT_RST;
            small_limit_reg <= ffpa_pkg::SMALL_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ffpa_pkg::CFG_HARD_LIMIT:
                    limit_page_reg <= cfg_wdata[ffpa_pkg::HARD_W-1:0];
                ffpa_pkg::CFG_SMALL_LIMIT:
                    small_limit_reg <= cfg_wdata[ffpa_pkg::SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    ffpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_data      (s_data),
        .limit_page  (limit_page_reg),
        .small_limit (small_limit_reg),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

// ===== rtl/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer: table clear after reset, request decode, free lookup and
// first-fit scan, then hand-off to the result register.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffpa_pkg::dp_sts_t   sts,
    output ffpa_pkg::ctrl_cmd_t cmd
);

    ffpa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffpa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffpa_pkg::S_CLEAR: begin
                if (sts.clr_last) state_next = ffpa_pkg::S_IDLE;
            end
            ffpa_pkg::S_IDLE: begin
                if (s_valid) state_next = ffpa_pkg::S_CHECK;
            end
            ffpa_pkg::S_CHECK: begin
                if (sts.early_done)   state_next = ffpa_pkg::S_DONE;
                else if (sts.is_free) state_next = ffpa_pkg::S_FREE_CHK;
                else                  state_next = ffpa_pkg::S_SCAN;
            end
            ffpa_pkg::S_FREE_CHK: begin
                state_next = ffpa_pkg::S_DONE;
            end
            ffpa_pkg::S_SCAN: begin
                if (sts.idx_out) state_next = ffpa_pkg::S_DONE;
                else             state_next = ffpa_pkg::S_SCAN_CHK;
            end
            ffpa_pkg::S_SCAN_CHK: begin
                if (sts.fit) state_next = ffpa_pkg::S_DONE;
                else         state_next = ffpa_pkg::S_SCAN;
            end
            ffpa_pkg::S_DONE: begin
                if (sts.out_free) state_next = ffpa_pkg::S_IDLE;
            end
            default: state_next = ffpa_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ffpa_pkg::S_CLEAR:    cmd.clr_en = 1'b1;
            ffpa_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ffpa_pkg::S_CHECK:    cmd.check    = 1'b1;
            ffpa_pkg::S_FREE_CHK: cmd.free_chk = 1'b1;
            ffpa_pkg::S_SCAN:     cmd.scan_rd  = 1'b1;
            ffpa_pkg::S_SCAN_CHK: cmd.scan_chk = 1'b1;
            ffpa_pkg::S_DONE:     cmd.load_out = sts.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ffpa_datapath.sv =====
// ----------------------------------------------------------------------------
// ffpa_datapath
// Page run table, request checks, scan pointer and run counters, result
// register with its output beat.
// ----------------------------------------------------------------------------
module ffpa_datapath #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ffpa_pkg::ctrl_cmd_t               cmd,
    output ffpa_pkg::dp_sts_t                 sts,
    input  ffpa_pkg::in_t                     s_data,
    input  logic [ffpa_pkg::HARD_W-1:0]       limit_page,
    input  logic [ffpa_pkg::SMALL_W-1:0]      small_limit,
    input  logic                              m_ready,
    output logic                              m_valid,
    output ffpa_pkg::out_t                    m_data
);

    localparam int IDX_W    = $clog2(NUM_PAGES);
    localparam int CNT_W    = $clog2(NUM_PAGES + 1);
    localparam int SCAN_MIN = ffpa_pkg::HARD_W + 1;
    localparam int SCAN_W   = ($clog2(2 * NUM_PAGES) > SCAN_MIN) ?
                              $clog2(2 * NUM_PAGES) : SCAN_MIN;
    localparam int BYTES_W  = ffpa_pkg::SIZE_W + 1;
    localparam logic [63:0] HEAP_BYTES = 64'(NUM_PAGES) * 64'(ffpa_pkg::PAGE_BYTES);

    logic [CNT_W-1:0]  page_mem [NUM_PAGES];

    ffpa_pkg::in_t     req_reg;
    ffpa_pkg::out_t    res_reg, res_next;
    ffpa_pkg::out_t    m_data_reg;
    logic              m_valid_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [SCAN_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0]  rd_data_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  wr_data;

    logic               early_done;
    ffpa_pkg::status_t  early_status;
    logic [BYTES_W-1:0] bytes_sum;
    logic               entry_zero;
    logic               fit;
    logic [IDX_W-1:0]   fit_addr;
    logic [CNT_W-1:0]   run_inc;
    logic               idx_out;

    // request classification, valid while in the check state
    always_comb begin
        early_done   = 1'b1;
        early_status = ffpa_pkg::ST_OK;
        if (req_reg.mode == ffpa_pkg::MODE_ALLOC) begin
            priority if (req_reg.size_bytes == '0) begin
                early_status = ffpa_pkg::ST_ZERO;
            end else if (req_reg.size_bytes <= ffpa_pkg::SIZE_W'(small_limit)) begin
                early_status = ffpa_pkg::ST_BLOCK;
            end else if (64'(req_reg.size_bytes) > HEAP_BYTES) begin
                early_status = ffpa_pkg::ST_NO_SPACE;
            end else begin
                early_done = 1'b0;
            end
        end else begin
            priority if (req_reg.page_index < limit_page) begin
                early_status = ffpa_pkg::ST_BLOCK;
            end else if (req_reg.page_index == limit_page ||
                         SCAN_W'(req_reg.page_index) >= SCAN_W'(NUM_PAGES)) begin
                early_status = ffpa_pkg::ST_INVALID;
            end else begin
                early_done = 1'b0;
            end
        end
    end

    assign idx_out    = idx_reg >= SCAN_W'(NUM_PAGES);
    assign entry_zero = rd_data_reg == '0;
    assign bytes_sum  = bytes_reg + BYTES_W'(ffpa_pkg::PAGE_BYTES);
    assign fit        = entry_zero && (bytes_sum >= BYTES_W'(req_reg.size_bytes));
    assign run_inc    = run_reg + CNT_W'(1);
    assign fit_addr   = (run_reg == '0) ? idx_reg[IDX_W-1:0] : first_reg;

    assign rd_addr = (req_reg.mode == ffpa_pkg::MODE_FREE) ?
                     IDX_W'(req_reg.page_index) : idx_reg[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        priority if (cmd.clr_en) begin
            wr_en = 1'b1;
        end else if (cmd.free_chk && !entry_zero) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(req_reg.page_index);
        end else if (cmd.scan_chk && fit) begin
            wr_en   = 1'b1;
            wr_addr = fit_addr;
            wr_data = run_inc;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) page_mem[wr_addr] <= wr_data;
        rd_data_reg <= page_mem[rd_addr];
    end

    // scan pointer, running gap size and pending result
    always_comb begin
        idx_next   = idx_reg;
        run_next   = run_reg;
        first_next = first_reg;
        bytes_next = bytes_reg;
        res_next   = res_reg;
        if (cmd.check) begin
            idx_next   = SCAN_W'(limit_page) + SCAN_W'(1);
            run_next   = '0;
            bytes_next = '0;
            res_next   = '{status: early_status, start_page: '0, freed_pages: '0};
        end
        if (cmd.free_chk) begin
            if (entry_zero) begin
                res_next = '{status: ffpa_pkg::ST_NOTHING, start_page: '0, freed_pages: '0};
            end else begin
                res_next = '{status: ffpa_pkg::ST_OK, start_page: '0,
                             freed_pages: ffpa_pkg::FREED_W'(rd_data_reg)};
            end
        end
        if (cmd.scan_rd && idx_out) begin
            res_next = '{status: ffpa_pkg::ST_NO_SPACE, start_page: '0, freed_pages: '0};
        end
        if (cmd.scan_chk) begin
            if (fit) begin
                res_next = '{status: ffpa_pkg::ST_OK,
                             start_page: ffpa_pkg::PAGE_W'(fit_addr), freed_pages: '0};
            end else if (entry_zero) begin
                if (run_reg == '0) first_next = idx_reg[IDX_W-1:0];
                run_next   = run_inc;
                bytes_next = bytes_sum;
                idx_next   = idx_reg + SCAN_W'(1);
            end else begin
                // hop over the allocated run
                run_next   = '0;
                bytes_next = '0;
                idx_next   = idx_reg + SCAN_W'(rd_data_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        run_reg   <= run_next;
        first_reg <= first_next;
        bytes_reg <= bytes_next;
        res_reg   <= res_next;
        if (cmd.capture)  req_reg    <= s_data;
        if (cmd.load_out) m_data_reg <= res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_en) clr_reg <= clr_reg + IDX_W'(1);
            if (cmd.load_out)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    assign sts.clr_last   = clr_reg == IDX_W'(NUM_PAGES - 1);
    assign sts.early_done = early_done;
    assign sts.is_free    = req_reg.mode == ffpa_pkg::MODE_FREE;
    assign sts.idx_out    = idx_out;
    assign sts.fit        = fit;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ffpa_pkg::ST_OK) |->
        (m_data_reg.start_page == '0 && m_data_reg.freed_pages == '0))
        else $error("failed request carries nonzero page fields");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded over a pending beat");

    a_gap_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_chk |-> (bytes_reg < BYTES_W'(req_reg.size_bytes)))
        else $error("scan gap already covers the request");
`endif

endmodule

// ===== tb/tb_first_fit_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_allocator_unit
// Self-checking bench for the first-fit page allocator. Requests go in over a
// valid/ready channel while a page-table mirror predicts every result beat;
// a checker compares each beat field by field against the oldest prediction.
// Directed corner cases come first, then backpressure, then random traffic
// under three idle profiles and several limit settings.
// ----------------------------------------------------------------------------
module tb_first_fit_page_allocator_unit;

    localparam int HEAP_PAGES     = ffpa_pkg::NUM_PAGES_DEF;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int TAIL_CYCLES    = 2 * HEAP_PAGES + 16;
    localparam int ITEMS_PER_MIX  = 530;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ffpa_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    ffpa_pkg::out_t                  m_data;
    logic                            cfg_we;
    logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // mirror of the heap: run length at the first page of each live run
    logic [ffpa_pkg::FREED_W-1:0] run_len_at [HEAP_PAGES];
    logic [ffpa_pkg::HARD_W-1:0]  limit_page;
    logic [ffpa_pkg::SMALL_W-1:0] small_limit;

    ffpa_pkg::out_t expected_results [$];
    ffpa_pkg::out_t want_beat;
    int   fail_count;
    int   quiet_cycles;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   rx_hold_len;
    int   rx_hold_reqs;
    int   rx_hold_seen;
    int   rx_hold_left;

    first_fit_page_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result of one request; updates the heap mirror as the block would.
    function automatic ffpa_pkg::out_t page_heap_outcome(input ffpa_pkg::in_t req);
        ffpa_pkg::out_t res;
        int unsigned    npages;
        int unsigned    idx;
        int unsigned    run;
        int unsigned    first;
        bit             placed;
        res = '{status: ffpa_pkg::ST_OK, start_page: '0, freed_pages: '0};
        if (req.mode == ffpa_pkg::MODE_ALLOC) begin
            if (req.size_bytes == 0) begin
                res.status = ffpa_pkg::ST_ZERO;
            end else if (req.size_bytes <= small_limit) begin
                res.status = ffpa_pkg::ST_BLOCK;
            end else begin
                npages = (req.size_bytes + ffpa_pkg::PAGE_BYTES - 1) / ffpa_pkg::PAGE_BYTES;
                placed = 1'b0;
                if (npages <= HEAP_PAGES) begin
                    idx   = limit_page + 1;
                    run   = 0;
                    first = 0;
                    while (!placed && idx < HEAP_PAGES) begin
                        if (run_len_at[idx] == 0) begin
                            run++;
                            if (run == 1)
                                first = idx;
                            if (run == npages) begin
                                run_len_at[first] = ffpa_pkg::FREED_W'(npages);
                                res.start_page    = ffpa_pkg::PAGE_W'(first);
                                placed            = 1'b1;
                            end
                            idx++;
                        end else begin
                            run = 0;
                            idx += run_len_at[idx];
                        end
                    end
                end
                if (!placed)
                    res.status = ffpa_pkg::ST_NO_SPACE;
            end
        end else begin
            if (req.page_index < limit_page) begin
                res.status = ffpa_pkg::ST_BLOCK;
            end else if (req.page_index == limit_page || req.page_index >= HEAP_PAGES) begin
                res.status = ffpa_pkg::ST_INVALID;
            end else if (run_len_at[req.page_index] == 0) begin
                res.status = ffpa_pkg::ST_NOTHING;
            end else begin
                res.freed_pages = run_len_at[req.page_index];
                run_len_at[req.page_index] = '0;
            end
        end
        return res;
    endfunction

    // Mostly allocations of a few pages and frees of live runs; some noise.
    function automatic ffpa_pkg::in_t next_heap_request();
        ffpa_pkg::in_t req;
        int unsigned   live [$];
        int unsigned   npg;
        for (int p = limit_page + 1; p < HEAP_PAGES; p++)
            if (run_len_at[p] != 0)
                live.push_back(p);
        req.mode       = ffpa_pkg::MODE_ALLOC;
        req.size_bytes = ffpa_pkg::SIZE_W'($urandom());
        req.page_index = ffpa_pkg::PAGE_W'($urandom());
        if ($urandom_range(99) < 80) begin
            if (live.size() > 0 &&
                $urandom_range(99) < ((live.size() >= 24) ? 75 : 35)) begin
                req.mode       = ffpa_pkg::MODE_FREE;
                req.page_index = ffpa_pkg::PAGE_W'(live[$urandom_range(live.size() - 1)]);
            end else begin
                npg = ($urandom_range(99) < 97) ? $urandom_range(1, 8)
                                                : $urandom_range(9, 64);
                req.size_bytes = ffpa_pkg::SIZE_W'((npg - 1) * ffpa_pkg::PAGE_BYTES +
                                 $urandom_range(1, ffpa_pkg::PAGE_BYTES));
            end
        end else begin
            req.mode = ffpa_pkg::mode_t'($urandom_range(1));
            case ($urandom_range(3))
                0: req.size_bytes = '0;
                1: req.size_bytes = ffpa_pkg::SIZE_W'($urandom_range(1, 4096));
                2: req.size_bytes = ffpa_pkg::SIZE_W'($urandom_range(1,
                                        16 * ffpa_pkg::PAGE_BYTES));
                default: ; // full width, beyond the heap in about half the draws
            endcase
        end
        return req;
    endfunction

    // Leaves s_valid high on return; release_and_drain drops it.
    task automatic send_request(input ffpa_pkg::in_t req);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(page_heap_outcome(req));
    endtask

    task automatic alloc_bytes(input int unsigned nbytes);
        send_request('{mode: ffpa_pkg::MODE_ALLOC, size_bytes: nbytes[ffpa_pkg::SIZE_W-1:0],
                       page_index: ffpa_pkg::PAGE_W'($urandom())});
    endtask

    task automatic free_page(input int unsigned pg);
        send_request('{mode: ffpa_pkg::MODE_FREE, size_bytes: ffpa_pkg::SIZE_W'($urandom()),
                       page_index: pg[ffpa_pkg::PAGE_W-1:0]});
    endtask

    task automatic release_and_drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic program_limits(input logic [ffpa_pkg::HARD_W-1:0] hard,
                                  input logic [ffpa_pkg::SMALL_W-1:0] small_bytes);
        cfg_we    <= 1'b1;
        cfg_index <= ffpa_pkg::CFG_HARD_LIMIT;
        cfg_wdata <= ffpa_pkg::CFG_DATA_W'(hard);
        @(posedge aclk);
        cfg_index <= ffpa_pkg::CFG_SMALL_LIMIT;
        cfg_wdata <= ffpa_pkg::CFG_DATA_W'(small_bytes);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        limit_page  = hard;
        small_limit = small_bytes;
    endtask

    task automatic test_default_limits();
        alloc_bytes(0);
        alloc_bytes(1);
        alloc_bytes(2048);                  // right at the small-block limit
        alloc_bytes(2049);                  // one page, lands on page 1
        alloc_bytes(23'h7FFFFF);            // more pages than the heap has
        alloc_bytes(HEAP_PAGES * ffpa_pkg::PAGE_BYTES); // full scan, no gap that big
        free_page(0);                       // the hard-limit page itself
        free_page(1);
        free_page(1);                       // double free
        alloc_bytes((HEAP_PAGES - 1) * ffpa_pkg::PAGE_BYTES);
        free_page(512);                     // middle of a run
        alloc_bytes(8192);                  // heap full
        free_page(1);
        free_page(HEAP_PAGES - 1);          // never the start of a run
    endtask

    task automatic test_limit_extremes();
        release_and_drain();
        program_limits(10'd1023, 13'd0);
        alloc_bytes(1);                     // limit on the last page: no gap
        free_page(1023);
        free_page(0);
        release_and_drain();
        program_limits(10'd1020, 13'd8191); // small limit at its top value
        alloc_bytes(8191);
        alloc_bytes(8192);
        alloc_bytes(8193);
        free_page(1021);
        free_page(1020);
        free_page(1019);
        free_page(1022);
        release_and_drain();
        program_limits(10'd1022, 13'd4096);
        alloc_bytes(4096);
        alloc_bytes(4097);
    endtask

    // Receiver stalls long enough for the block to fill and hold off input.
    task automatic test_result_backpressure();
        release_and_drain();
        program_limits(ffpa_pkg::HARD_LIMIT_RST, ffpa_pkg::SMALL_LIMIT_RST);
        tx_idle_pct = 0;
        rx_hold_len = 300;
        rx_hold_reqs++;
        repeat (12) alloc_bytes($urandom_range(2049, 3 * ffpa_pkg::PAGE_BYTES));
        release_and_drain();
    endtask

    task automatic test_random_traffic();
        for (int mix = 0; mix < 3; mix++) begin
            release_and_drain();
            case (mix)
                0: begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 77;
                    program_limits(ffpa_pkg::HARD_W'($urandom_range(0, 255)),
                                   ffpa_pkg::SMALL_W'($urandom_range(0, 4096)));
                end
                1: begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 23;
                    program_limits(10'd0, ffpa_pkg::SMALL_W'($urandom_range(0, 4096)));
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    program_limits(ffpa_pkg::HARD_W'($urandom_range(256, 900)),
                                   ffpa_pkg::SMALL_W'($urandom_range(0, 4096)));
                end
            endcase
            repeat (ITEMS_PER_MIX) send_request(next_heap_request());
        end
    endtask

    initial begin
        m_ready      <= 1'b0;
        rx_hold_left  = 0;
        rx_hold_seen  = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_reqs != rx_hold_seen) begin
                rx_hold_left = rx_hold_len;
                rx_hold_seen = rx_hold_reqs;
            end
            if (rx_hold_left != 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $error("result beat with no request outstanding");
            end else begin
                want_beat = expected_results.pop_front();
                if (m_data.status !== want_beat.status) begin
                    fail_count++;
                    $error("status: expected %0d, got %0d",
                           want_beat.status, m_data.status);
                end
                if (m_data.start_page !== want_beat.start_page) begin
                    fail_count++;
                    $error("start_page: expected %0d, got %0d",
                           want_beat.start_page, m_data.start_page);
                end
                if (m_data.freed_pages !== want_beat.freed_pages) begin
                    fail_count++;
                    $error("freed_pages: expected %0d, got %0d",
                           want_beat.freed_pages, m_data.freed_pages);
                end
            end
        end
    end

    // Covers the table clear after reset and the longest scan many times over.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        aresetn     <= 1'b0;
        tx_idle_pct  = 23;
        rx_idle_pct  = 77;
        foreach (run_len_at[p])
            run_len_at[p] = '0;
        limit_page  = ffpa_pkg::HARD_LIMIT_RST;
        small_limit = ffpa_pkg::SMALL_LIMIT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_limits();
        test_limit_extremes();
        test_result_backpressure();
        test_random_traffic();

        release_and_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ffpa_pkg.sv
rtl/ffpa_ctrl.sv
rtl/ffpa_datapath.sv
rtl/first_fit_page_allocator_unit.sv
tb/tb_first_fit_page_allocator_unit.sv
